/* rtl/ssit_pkg.sv */
// Shared types and constants for the sorted sparse index table.
// Holds the transfer payload structs, op codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package ssit_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int POSITION_W    = 6;
   localparam int OP_W          = 3;
   localparam int RSP_POS_W     = 7;
   localparam int RSP_TOTAL_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_SET          = 3'd0,
      OP_GET          = 3'd1,
      OP_TAKE         = 3'd2,
      OP_ITEM_AT      = 3'd3,
      OP_REMOVE_FIRST = 3'd4,
      OP_GET_INDEX    = 3'd5
   } op_code_type;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [KEY_W-1:0]      key;
      logic [VALUE_W-1:0]    value;
      logic [POSITION_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [VALUE_W-1:0]     result_value;
      logic [RSP_POS_W-1:0]   result_position;
      logic [RSP_TOTAL_W-1:0] entry_total;
      logic                   full_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_COMPARE,
      ST_VALUE,
      ST_SHIFT_INS,
      ST_SHIFT_DEL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic item_pos;
      logic read_item;
      logic read_first;
      logic search_issue;
      logic search_step;
      logic search_miss;
      logic set_full;
      logic set_overwrite;
      logic take_value;
      logic ins_start;
      logic del_start;
      logic del_at_first;
      logic shift_ins;
      logic shift_del;
      logic ins_finish;
      logic del_finish;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            lo_lt_hi;
      logic            key_eq;
      logic            pos_ok;
      logic            nonempty;
      logic            full;
      logic            shift_busy;
   } ctrl_status_type;

endpackage

/* rtl/ssit_datapath.sv */
// Datapath of the sorted sparse index table: entry memory, search bounds,
// shift pointer and result register. Driven by ssit_ctrl commands.
// Depends on ssit_pkg.
module ssit_datapath import ssit_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_i,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   output rsp_type         rsp_o
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
   localparam int ENTRY_W = KEY_W + VALUE_W;

   logic [ENTRY_W-1:0] entry_mem [DEPTH];

   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [IDX_W-1:0]   sp_ff, sp_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               res_found_ff, res_found_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [RSP_POS_W-1:0] res_pos_ff, res_pos_in;
   logic               res_ferr_ff, res_ferr_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CNT_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid_idx;
   logic [IDX_W-1:0]   del_base;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic [KEY_W-1:0]   rd_key;
   logic [VALUE_W-1:0] rd_val;

   assign rd_key  = rd_data_ff[ENTRY_W-1:VALUE_W];
   assign rd_val  = rd_data_ff[VALUE_W-1:0];
   // lo < hi whenever a probe is issued, so hi - 1 never underflows
   assign mid_sum = ({1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W+1)'(1)) >> 1;
   assign mid_idx = mid_sum[IDX_W-1:0];
   assign del_base = cmd.del_at_first ? '0 : mid_ff;

   assign status.op         = req_ff.op;
   assign status.lo_lt_hi   = lo_ff < hi_ff;
   assign status.key_eq     = rd_key == req_ff.key;
   assign status.pos_ok     = CMP_W'(req_ff.position) < CMP_W'(count_ff);
   assign status.nonempty   = count_ff != '0;
   assign status.full       = count_ff == CNT_W'(DEPTH);
   assign status.shift_busy = (rem_ff != '0) || wr_pend_ff;

   assign rsp_o = rsp_ff;

   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      sp_in        = sp_ff;
      rem_in       = rem_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      res_found_in = res_found_ff;
      res_value_in = res_value_ff;
      res_pos_in   = res_pos_ff;
      res_ferr_in  = res_ferr_ff;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      // a shift read from the previous cycle lands one slot over
      mem_we       = wr_pend_ff;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_data  = rd_data_ff;

      if (cmd.capture) begin
         req_in       = req_i;
         lo_in        = '0;
         hi_in        = count_ff;
         res_found_in = 1'b0;
         res_value_in = '0;
         res_pos_in   = '0;
         res_ferr_in  = 1'b0;
      end
      if (cmd.item_pos) begin
         res_pos_in = RSP_POS_W'(req_ff.position);
      end
      if (cmd.read_item) begin
         rd_addr = IDX_W'(req_ff.position);
      end
      if (cmd.read_first) begin
         rd_addr = '0;
      end
      if (cmd.search_issue) begin
         rd_addr = mid_idx;
         mid_in  = mid_idx;
      end
      if (cmd.search_step) begin
         if (status.key_eq) begin
            res_found_in = 1'b1;
            res_value_in = rd_val;
            res_pos_in   = RSP_POS_W'(mid_ff);
         end else if (req_ff.key < rd_key) begin
            hi_in = CNT_W'(mid_ff);
         end else begin
            lo_in = CNT_W'(mid_ff) + CNT_W'(1);
         end
      end
      if (cmd.search_miss) begin
         res_pos_in = RSP_POS_W'(lo_ff);
      end
      if (cmd.set_full) begin
         res_ferr_in = 1'b1;
      end
      if (cmd.set_overwrite) begin
         mem_we      = 1'b1;
         mem_wr_addr = mid_ff;
         mem_wr_data = {req_ff.key, req_ff.value};
      end
      if (cmd.take_value) begin
         res_found_in = 1'b1;
         res_value_in = rd_val;
      end
      if (cmd.ins_start) begin
         sp_in  = IDX_W'(count_ff - CNT_W'(1));
         rem_in = count_ff - lo_ff;
      end
      if (cmd.del_start) begin
         sp_in  = del_base + IDX_W'(1);
         rem_in = count_ff - CNT_W'(del_base) - CNT_W'(1);
      end
      // stream one entry a cycle: read here, write next cycle
      if ((cmd.shift_ins || cmd.shift_del) && (rem_ff != '0)) begin
         rd_addr    = sp_ff;
         rem_in     = rem_ff - CNT_W'(1);
         wr_pend_in = 1'b1;
         if (cmd.shift_ins) begin
            sp_in      = sp_ff - IDX_W'(1);
            wr_addr_in = sp_ff + IDX_W'(1);
         end else begin
            sp_in      = sp_ff + IDX_W'(1);
            wr_addr_in = sp_ff - IDX_W'(1);
         end
      end
      if (cmd.ins_finish) begin
         mem_we      = 1'b1;
         mem_wr_addr = lo_ff[IDX_W-1:0];
         mem_wr_data = {req_ff.key, req_ff.value};
         count_in    = count_ff + CNT_W'(1);
      end
      if (cmd.del_finish) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_in.found           = res_found_ff;
         rsp_in.result_value    = res_value_ff;
         rsp_in.result_position = res_pos_ff;
         rsp_in.entry_total     = RSP_TOTAL_W'(count_ff);
         rsp_in.full_error      = res_ferr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rem_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rem_ff     <= rem_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      sp_ff        <= sp_in;
      wr_addr_ff   <= wr_addr_in;
      res_found_ff <= res_found_in;
      res_value_ff <= res_value_in;
      res_pos_ff   <= res_pos_in;
      res_ferr_ff  <= res_ferr_in;
      rsp_ff       <= rsp_in;
   end

endmodule

/* rtl/ssit_ctrl.sv */
// Controller of the sorted sparse index table: sequences decode, binary
// search, entry shifts and the response transfer. Depends on ssit_pkg.
module ssit_ctrl import ssit_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               OP_SET, OP_GET, OP_TAKE, OP_GET_INDEX: begin
                  state_in = ST_SEARCH;
               end
               OP_ITEM_AT: begin
                  cmd.item_pos = 1'b1;
                  if (status.pos_ok) begin
                     cmd.read_item = 1'b1;
                     state_in      = ST_VALUE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               OP_REMOVE_FIRST: begin
                  if (status.nonempty) begin
                     cmd.read_first = 1'b1;
                     state_in       = ST_VALUE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SEARCH: begin
            if (status.lo_lt_hi) begin
               cmd.search_issue = 1'b1;
               state_in         = ST_COMPARE;
            end else begin
               // no match: lo is the insertion point
               cmd.search_miss = 1'b1;
               if (status.op == OP_SET) begin
                  if (status.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = ST_FINISH;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = ST_SHIFT_INS;
                  end
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_COMPARE: begin
            cmd.search_step = 1'b1;
            if (status.key_eq) begin
               if (status.op == OP_SET) begin
                  cmd.set_overwrite = 1'b1;
                  state_in          = ST_FINISH;
               end else if (status.op == OP_TAKE) begin
                  cmd.del_start = 1'b1;
                  state_in      = ST_SHIFT_DEL;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_VALUE: begin
            cmd.take_value = 1'b1;
            if (status.op == OP_REMOVE_FIRST) begin
               cmd.del_start    = 1'b1;
               cmd.del_at_first = 1'b1;
               state_in         = ST_SHIFT_DEL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT_INS: begin
            if (status.shift_busy) begin
               cmd.shift_ins = 1'b1;
            end else begin
               cmd.ins_finish = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_SHIFT_DEL: begin
            if (status.shift_busy) begin
               cmd.shift_del = 1'b1;
            end else begin
               cmd.del_finish = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/sorted_sparse_index_table.sv */
// Channel  Ports                          Transfer when
// req      req_valid req_ready req        req_valid && req_ready
// rsp      rsp_valid rsp_ready rsp        rsp_valid && rsp_ready
//
// One item at a time. A key op runs a binary search, each probe a registered memory
// read followed by a key compare; an insert or delete then moves the entries past
// the slot one at a time, and decode, search exit, write-back and handoff complete it.
// One read and one write a cycle on the entry memory set the pace. Reset is
// synchronous and empties the table; stored entries are not cleared. A stalled
// response is held in the output register while the next request is already taken.
module sorted_sparse_index_table import ssit_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ssit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssit_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_i  (req),
      .cmd    (cmd),
      .status (status),
      .rsp_o  (rsp)
   );

endmodule

/* rtl/ssit_checker.sv */
// Port-level checks for the sorted sparse index table, bound to the top level.
// Depends on ssit_pkg and sorted_sparse_index_table.
module ssit_checker import ssit_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // a waiting response transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 127) || (rsp.entry_total <= RSP_TOTAL_W'(DEPTH)))
      else $error("entry_total above table depth");

   // a refused set reports neither a hit nor a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.full_error |-> !rsp.found && (rsp.result_value == '0))
      else $error("full_error with found or value");

   // one item at a time: no request transfer right after another
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready right after a request transfer");

endmodule

bind sorted_sparse_index_table ssit_checker #(.DEPTH(DEPTH)) u_ssit_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

/* sim/ssit_table_checker.sv */
`timescale 1ns / 1ps
// Response checker for the sorted sparse index table: keeps a shadow of the sorted
// key/value table, predicts one response per request transfer and compares them.
// Depends on ssit_pkg for the payload structs and op codes.
module ssit_table_checker import ssit_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp,
   output int      mismatch_count,
   output int      replies_owed,
   output int      replies_checked
);
   logic [KEY_W-1:0]   shadow_keys   [DEPTH];
   logic [VALUE_W-1:0] shadow_values [DEPTH];
   int unsigned        shadow_count;
   rsp_type            replies_due [$];

   // Binary search: the matching slot, or the insertion point on a miss.
   function automatic bit search_key(input logic [KEY_W-1:0] key, output int unsigned slot);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = (lo + hi - 1) >> 1;
         if (shadow_keys[mid] == key) begin
            slot = mid;
            return 1'b1;
         end
         if (key < shadow_keys[mid]) hi = mid;
         else lo = mid + 1;
      end
      slot = lo;
      return 1'b0;
   endfunction

   function automatic void drop_entry(input int unsigned slot);
      int unsigned i;
      for (i = slot; i + 1 < shadow_count; i++) begin
         shadow_keys[i]   = shadow_keys[i + 1];
         shadow_values[i] = shadow_values[i + 1];
      end
      shadow_count--;
   endfunction

   // Apply one operation to the shadow table and return the response it owes.
   function automatic rsp_type table_step(input req_type item);
      rsp_type     reply;
      int unsigned slot;
      int unsigned i;
      bit          hit;
      reply = '0;
      case (item.op)
         OP_SET: begin
            hit = search_key(item.key, slot);
            reply.result_position = RSP_POS_W'(slot);
            if (hit) begin
               reply.found         = 1'b1;
               reply.result_value  = shadow_values[slot];
               shadow_values[slot] = item.value;
            end else if (shadow_count >= DEPTH) begin
               reply.full_error = 1'b1;
            end else begin
               for (i = shadow_count; i > slot; i--) begin
                  shadow_keys[i]   = shadow_keys[i - 1];
                  shadow_values[i] = shadow_values[i - 1];
               end
               shadow_keys[slot]   = item.key;
               shadow_values[slot] = item.value;
               shadow_count++;
            end
         end
         OP_GET, OP_GET_INDEX: begin
            hit = search_key(item.key, slot);
            reply.result_position = RSP_POS_W'(slot);
            if (hit) begin
               reply.found        = 1'b1;
               reply.result_value = shadow_values[slot];
            end
         end
         OP_TAKE: begin
            hit = search_key(item.key, slot);
            reply.result_position = RSP_POS_W'(slot);
            if (hit) begin
               reply.found        = 1'b1;
               reply.result_value = shadow_values[slot];
               drop_entry(slot);
            end
         end
         OP_ITEM_AT: begin
            reply.result_position = RSP_POS_W'(item.position);
            if (item.position < shadow_count) begin
               reply.found        = 1'b1;
               reply.result_value = shadow_values[item.position];
            end
         end
         OP_REMOVE_FIRST: begin
            if (shadow_count > 0) begin
               reply.found        = 1'b1;
               reply.result_value = shadow_values[0];
               drop_entry(0);
            end
         end
         default: ;
      endcase
      reply.entry_total = RSP_TOTAL_W'(shadow_count);
      return reply;
   endfunction

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_count = 0;
         replies_due.delete();
         replies_owed = 0;
      end else begin
         // Retire the response first; a new request cannot be answered on its own edge.
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (replies_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
            end else begin
               want = replies_due.pop_front();
               check_field("found", want.found, rsp.found);
               check_field("result_value", want.result_value, rsp.result_value);
               check_field("result_position", want.result_position, rsp.result_position);
               check_field("entry_total", want.entry_total, rsp.entry_total);
               check_field("full_error", want.full_error, rsp.full_error);
            end
         end
         if (req_valid && req_ready) replies_due.push_back(table_step(req));
         replies_owed = replies_due.size();
      end
   end

endmodule

/* sim/sorted_sparse_index_table_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted sparse index table: clock, reset, request traffic
// and response back-pressure with random gaps, and the final verdict.
// Depends on ssit_pkg, sorted_sparse_index_table and ssit_table_checker.
module sorted_sparse_index_table_tb;
   import ssit_pkg::*;

   localparam int               CLOCK_PERIOD  = 8;
   localparam int               RESET_CYCLES  = 10;
   localparam int               RANDOM_ITEMS  = 1600;
   localparam int               PHASE_ITEMS   = 200;
   localparam int               DRAIN_AT      = 700;
   localparam int               HOLD_AT       = 200;
   localparam int               HOLD_CYCLES   = 1000;
   localparam int               SETTLE_CYCLES = 100;
   localparam int               CYCLE_LIMIT   = 2000000;
   localparam int               POOL_MAX      = 96;
   localparam logic [OP_W-1:0]  OP_SPARE_A    = 3'd6;
   localparam logic [OP_W-1:0]  OP_SPARE_B    = 3'd7;
   localparam logic [KEY_W-1:0] KEY_TOP       = '1;
   localparam logic [KEY_W-1:0] KEY_MID       = 32'h8000_0000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             rsp_ready = 1'b0;
   req_type          req       = '0;
   logic             req_ready;
   logic             rsp_valid;
   rsp_type          rsp;
   int               mismatch_count;
   int               replies_owed;
   int               replies_checked;
   logic [KEY_W-1:0] key_pool [$];
   bit               fill_phase;
   bit               sender_quiet;

   sorted_sparse_index_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   ssit_table_checker shadow (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp),
      .mismatch_count  (mismatch_count),
      .replies_owed    (replies_owed),
      .replies_checked (replies_checked)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic req_type make_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [POSITION_W-1:0] position);
      req_type item;
      item.op       = op;
      item.key      = key;
      item.value    = value;
      item.position = position;
      return item;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (filling) begin
         if (roll < 60) return OP_SET;
         if (roll < 68) return OP_GET;
         if (roll < 72) return OP_TAKE;
         if (roll < 82) return OP_ITEM_AT;
         if (roll < 85) return OP_REMOVE_FIRST;
         if (roll < 96) return OP_GET_INDEX;
      end else begin
         if (roll < 10) return OP_SET;
         if (roll < 20) return OP_GET;
         if (roll < 55) return OP_TAKE;
         if (roll < 67) return OP_ITEM_AT;
         if (roll < 85) return OP_REMOVE_FIRST;
         if (roll < 96) return OP_GET_INDEX;
      end
      return roll[0] ? OP_SPARE_A : OP_SPARE_B;
   endfunction

   // Reuse recent keys so lookups hit; otherwise extremes, a dense low range or anything.
   function automatic logic [KEY_W-1:0] pick_key(input bit want_fresh);
      int roll;
      roll = $urandom_range(0, 99);
      if (!want_fresh && key_pool.size() > 0 && roll < 70)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (roll < 8) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return KEY_TOP;
            2:       return KEY_MID;
            default: return KEY_MID - 1;
         endcase
      end
      if (roll < 40) return KEY_W'($urandom_range(0, 1023));
      return $urandom;
   endfunction

   // Call at a falling edge; returns at the falling edge after the transfer.
   task automatic offer(input req_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (item.op == OP_SET) begin
         key_pool.push_back(item.key);
         if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
      end
   endtask

   initial begin : receiver
      int stall_left;
      int mode_left;
      int stall_pct;
      bit hold_done;
      stall_left = 0;
      mode_left  = 0;
      stall_pct  = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         // Alternate stretches of steady readiness with stretches of random stalls.
         if (mode_left == 0) begin
            mode_left = $urandom_range(100, 400);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         mode_left--;
         if (!hold_done && replies_checked >= HOLD_AT) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_type                 item;
      logic [OP_W-1:0]         op;
      logic [POSITION_W-1:0]   position;
      bit                      fresh;
      int                      gap;
      int                      i;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: misses, out-of-range read, remove on empty.
      offer(make_item(OP_GET, KEY_MID, '0, '0), 0);
      offer(make_item(OP_REMOVE_FIRST, '0, '0, '0), 0);
      offer(make_item(OP_ITEM_AT, '0, '0, '0), 0);
      offer(make_item(OP_TAKE, 32'd5, '0, '0), 0);
      offer(make_item(OP_GET_INDEX, KEY_TOP, '0, '0), 0);
      // Inserts at the key extremes and the middle, an overwrite, lookups and takes.
      offer(make_item(OP_SET, KEY_MID, '1, '0), 0);
      offer(make_item(OP_SET, '0, '0, '0), 0);
      offer(make_item(OP_SET, KEY_TOP, 32'h1234_5678, '0), 0);
      offer(make_item(OP_SET, '0, 32'hA5A5_A5A5, '0), 0);
      offer(make_item(OP_GET, '0, '0, '0), 0);
      offer(make_item(OP_GET_INDEX, 32'd7, '0, '0), 0);
      offer(make_item(OP_GET_INDEX, KEY_TOP, '0, '0), 0);
      offer(make_item(OP_ITEM_AT, '0, '0, 6'd2), 0);
      offer(make_item(OP_ITEM_AT, '1, '1, '1), 0);
      offer(make_item(OP_TAKE, KEY_MID, '0, '0), 0);
      offer(make_item(OP_TAKE, KEY_MID, '0, '0), 0);
      // Unused op codes leave the table alone; removes, a set and a get then empty it.
      offer(make_item(OP_SPARE_A, '1, '1, '1), 0);
      offer(make_item(OP_SPARE_B, '0, '0, '0), 0);
      offer(make_item(OP_REMOVE_FIRST, '1, '1, '1), 0);
      offer(make_item(OP_SET, 32'h5A5A_5A5A, 32'h0F0F_F0F0, '0), 0);
      offer(make_item(OP_GET, 32'h5A5A_5A5A, '0, '0), 0);
      offer(make_item(OP_REMOVE_FIRST, '0, '0, '0), 0);
      offer(make_item(OP_REMOVE_FIRST, '0, '0, '0), 0);
      offer(make_item(OP_ITEM_AT, '0, '0, '0), 0);

      // Alternate set-heavy phases that fill the table past full with
      // remove-heavy phases that drain it.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) fill_phase = ((i / PHASE_ITEMS) % 2 == 0);
         if (i % 100 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         if (i == DRAIN_AT) begin
            req_valid <= 1'b0;
            wait (replies_owed == 0);
            @(negedge clock);
         end
         op       = pick_op(fill_phase);
         fresh    = (op == OP_SET) && ($urandom_range(0, 99) < (fill_phase ? 75 : 40));
         position = ($urandom_range(0, 9) < 6) ? POSITION_W'($urandom_range(0, 15))
                                               : POSITION_W'($urandom_range(0, 63));
         item     = make_item(op, pick_key(fresh), $urandom, position);
         if (sender_quiet || $urandom_range(0, 99) < 40) gap = 0;
         else gap = pick_gap();
         offer(item, gap);
      end

      req_valid <= 1'b0;
      wait (replies_owed == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
